FILE: rtl/core/cac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cell area and centroid pipeline.
// No dependencies; every other file in rtl/core imports this package.
package cac_pkg;

  localparam int CW   = 24;
  localparam int DW   = 25;
  localparam int SW   = 26;
  localparam int PW   = 50;
  localparam int XW   = 51;
  localparam int AW   = 34;
  localparam int TW   = 35;
  localparam int DENW = 37;
  localparam int NW   = 61;
  localparam int QDW  = 48;
  localparam int QB   = 40;
  localparam int CQ   = 25;
  localparam int CENT_DLY = QB - CQ;

  localparam logic [31:0] TS_RESET = 32'h0100_0000;
  localparam logic CELL_TRI  = 1'b0;
  localparam logic CELL_QUAD = 1'b1;

  typedef struct packed {
    logic              cell_type;
    logic signed [23:0] node0_x;
    logic signed [23:0] node0_y;
    logic signed [23:0] node1_x;
    logic signed [23:0] node1_y;
    logic signed [23:0] node2_x;
    logic signed [23:0] node2_y;
    logic signed [23:0] node3_x;
    logic signed [23:0] node3_y;
  } in_t;

  typedef struct packed {
    logic signed [23:0] centroid_x;
    logic signed [23:0] centroid_y;
    logic [31:0]        cell_area;
    logic [39:0]        step_over_area;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic                 quad;
    logic [31:0]          ts;
    logic signed [SW-1:0] sxa;
    logic signed [SW-1:0] sya;
    logic signed [SW-1:0] sxb;
    logic signed [SW-1:0] syb;
    logic [AW-1:0]        area_a;
    logic [AW-1:0]        area_b;
  } geom_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        zero;
    logic [31:0] area;
    logic        degen;
  } side_t;

  typedef struct packed {
    logic [QDW-1:0]  dividend;
    logic [TW-1:0]   divisor;
    logic [NW-1:0]   num_x;
    logic [NW-1:0]   num_y;
    logic [DENW-1:0] den;
    side_t           side;
  } weight_t;

endpackage

FILE: rtl/core/cac_geom.sv
`timescale 1ns / 1ps
// Front three stages: edge differences and coordinate sums, cross products,
// and truncated triangle areas. Depends on cac_pkg.
module cac_geom
  import cac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_in,
  input  in_t         d_in,
  input  logic [31:0] ts,
  output logic        v_out,
  output geom_t       g
);

  logic                 v1, v2;
  logic                 quad1, quad2;
  logic [31:0]          ts1, ts2;
  logic signed [DW-1:0] d1x, d1y, d2x, d2y, d3x, d3y;
  logic signed [SW-1:0] sxa1, sya1, sxb1, syb1, sxa2, sya2, sxb2, syb2;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [XW-1:0] cra, crb;
  logic [XW-1:0]        ma, mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1 <= v_in;
      v2 <= v1;
      v_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= d_in.cell_type;
      ts1 <= ts;
      d1x <= DW'(d_in.node1_x) - DW'(d_in.node0_x);
      d1y <= DW'(d_in.node1_y) - DW'(d_in.node0_y);
      d2x <= DW'(d_in.node2_x) - DW'(d_in.node0_x);
      d2y <= DW'(d_in.node2_y) - DW'(d_in.node0_y);
      d3x <= DW'(d_in.node3_x) - DW'(d_in.node0_x);
      d3y <= DW'(d_in.node3_y) - DW'(d_in.node0_y);
      sxa1 <= SW'(d_in.node0_x) + SW'(d_in.node1_x) + SW'(d_in.node2_x);
      sya1 <= SW'(d_in.node0_y) + SW'(d_in.node1_y) + SW'(d_in.node2_y);
      sxb1 <= SW'(d_in.node0_x) + SW'(d_in.node3_x) + SW'(d_in.node2_x);
      syb1 <= SW'(d_in.node0_y) + SW'(d_in.node3_y) + SW'(d_in.node2_y);

      quad2 <= quad1;
      ts2 <= ts1;
      sxa2 <= sxa1;
      sya2 <= sya1;
      sxb2 <= sxb1;
      syb2 <= syb1;
      p1 <= d1x * d2y;
      p2 <= d2x * d1y;
      p3 <= d3x * d2y;
      p4 <= d2x * d3y;

      g.quad <= quad2;
      g.ts <= ts2;
      g.sxa <= sxa2;
      g.sya <= sya2;
      g.sxb <= sxb2;
      g.syb <= syb2;
      g.area_a <= ma[XW-1:17];
      g.area_b <= mb[XW-1:17];
    end
  end

  always_comb begin
    cra = XW'(p1) - XW'(p2);
    crb = XW'(p3) - XW'(p4);
    ma = cra[XW-1] ? XW'(-cra) : XW'(cra);
    mb = crb[XW-1] ? XW'(-crb) : XW'(crb);
  end

endmodule

FILE: rtl/core/cac_weight.sv
`timescale 1ns / 1ps
// Stages four and five: area sum, weighted coordinate products, and the
// operands of both dividers. Depends on cac_pkg.
module cac_weight
  import cac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    v_in,
  input  geom_t   g,
  output logic    v_out,
  output weight_t w
);

  logic                 v4;
  logic                 quad4;
  logic [31:0]          ts4;
  logic [AW-1:0]        area_a4;
  logic [TW-1:0]        tot4;
  logic signed [SW-1:0] sxa4, sya4;
  logic signed [NW-1:0] mxa, mxb, mya, myb;
  logic signed [NW-1:0] nx, ny;
  logic [31:0]          sat32;
  logic [TW-1:0]        area_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v4 <= v_in;
      v_out <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad4 <= g.quad;
      ts4 <= g.ts;
      area_a4 <= g.area_a;
      tot4 <= TW'(g.area_a) + (g.quad ? TW'(g.area_b) : TW'(0));
      sxa4 <= g.sxa;
      sya4 <= g.sya;
      mxa <= $signed({1'b0, g.area_a}) * g.sxa;
      mxb <= $signed({1'b0, g.area_b}) * g.sxb;
      mya <= $signed({1'b0, g.area_a}) * g.sya;
      myb <= $signed({1'b0, g.area_b}) * g.syb;

      w.dividend <= {ts4, 16'h0000};
      w.divisor <= quad4 ? TW'(sat32) : TW'(area_a4);
      w.num_x <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      w.num_y <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      w.den <= quad4 ? DENW'(tot4) + DENW'({tot4, 1'b0}) : DENW'(3);
      w.side.neg_x <= nx[NW-1];
      w.side.neg_y <= ny[NW-1];
      w.side.zero <= quad4 && (tot4 == '0);
      w.side.area <= quad4 ? sat32 : area_a4[31:0];
      w.side.degen <= (area_full == '0);
    end
  end

  always_comb begin
    nx = quad4 ? NW'(mxa + mxb) : NW'(sxa4);
    ny = quad4 ? NW'(mya + myb) : NW'(sya4);
    sat32 = (tot4[TW-1:32] != '0) ? 32'hFFFF_FFFF : tot4[31:0];
    area_full = quad4 ? tot4 : TW'(area_a4);
  end

endmodule

FILE: rtl/core/cac_div_quot.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the time step over area quotient, one
// quotient bit per stage, with overflow saturation. Depends on cac_pkg.
module cac_div_quot
  import cac_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [QDW-1:0] dividend,
  input  logic [TW-1:0]  divisor,
  output logic [QB-1:0]  quot
);

  logic [TW:0]   rem [0:QB];
  logic [QB-1:0] low [0:QB];
  logic [TW-1:0] dv  [0:QB];
  logic [QB-1:0] qq  [0:QB];
  logic          sat [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (TW+1)'(dividend[QDW-1:QB]);
      low[0] <= dividend[QB-1:0];
      dv[0] <= divisor;
      qq[0] <= '0;
      sat[0] <= TW'(dividend[QDW-1:QB]) >= divisor;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [TW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[k-1][TW-1:0], low[k-1][QB-1]};
      ge = trial >= {1'b0, dv[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? trial - {1'b0, dv[k-1]} : trial;
        low[k] <= {low[k-1][QB-2:0], 1'b0};
        dv[k] <= dv[k-1];
        qq[k] <= {qq[k-1][QB-2:0], ge};
        sat[k] <= sat[k-1];
      end
    end
  end

  assign quot = sat[QB] ? '1 : qq[QB];

endmodule

FILE: rtl/core/cac_div_cent.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the two centroid magnitudes over a shared
// denominator, one quotient bit per stage. Depends on cac_pkg.
module cac_div_cent
  import cac_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num_x,
  input  logic [NW-1:0]   num_y,
  input  logic [DENW-1:0] den,
  output logic [CQ-1:0]   qx,
  output logic [CQ-1:0]   qy
);

  logic [DENW:0]   rx [0:CQ];
  logic [DENW:0]   ry [0:CQ];
  logic [CQ-1:0]   lx [0:CQ];
  logic [CQ-1:0]   ly [0:CQ];
  logic [DENW-1:0] dn [0:CQ];
  logic [CQ-1:0]   ax [0:CQ];
  logic [CQ-1:0]   ay [0:CQ];

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= (DENW+1)'(num_x[NW-1:CQ]);
      ry[0] <= (DENW+1)'(num_y[NW-1:CQ]);
      lx[0] <= num_x[CQ-1:0];
      ly[0] <= num_y[CQ-1:0];
      dn[0] <= den;
      ax[0] <= '0;
      ay[0] <= '0;
    end
  end

  for (genvar k = 1; k <= CQ; k++) begin : g_stage
    logic [DENW:0] tx, ty;
    logic          gx, gy;
    always_comb begin
      tx = {rx[k-1][DENW-1:0], lx[k-1][CQ-1]};
      ty = {ry[k-1][DENW-1:0], ly[k-1][CQ-1]};
      gx = tx >= {1'b0, dn[k-1]};
      gy = ty >= {1'b0, dn[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx[k] <= gx ? tx - {1'b0, dn[k-1]} : tx;
        ry[k] <= gy ? ty - {1'b0, dn[k-1]} : ty;
        lx[k] <= {lx[k-1][CQ-2:0], 1'b0};
        ly[k] <= {ly[k-1][CQ-2:0], 1'b0};
        dn[k] <= dn[k-1];
        ax[k] <= {ax[k-1][CQ-2:0], gx};
        ay[k] <= {ay[k-1][CQ-2:0], gy};
      end
    end
  end

  assign qx = ax[CQ];
  assign qy = ay[CQ];

endmodule

FILE: rtl/core/cell_area_centroid.sv
`timescale 1ns / 1ps
// Top level of the cell area and centroid pipeline.
// Depends on cac_pkg, cac_geom, cac_weight, cac_div_quot and cac_div_cent.
//
// One cell is taken per cycle while the output is not stalled; its result
// passes five stages of differences, cross products, areas and weighted
// sums and then the 41-stage bit-per-stage divider that forms the time step
// over area quotient. A stall on the output freezes the whole pipeline, so
// the input is ready whenever the output register is empty or being taken.
// The time step register may be written only while no cell is in flight.
module cell_area_centroid
  import cac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic          en;
  logic [31:0]   ts;
  logic          gv, wv;
  geom_t         g;
  weight_t       w;
  logic [QB-1:0] quot;
  logic [CQ-1:0] qx, qy;
  side_t         sd [0:QB];
  logic          vd [0:QB];
  logic [CQ-1:0] cx [0:CENT_DLY-1];
  logic [CQ-1:0] cy [0:CENT_DLY-1];
  logic signed [SW-1:0] fx, fy;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts <= TS_RESET;
    end else if (cfg_we) begin
      ts <= cfg_data;
    end
  end

  cac_geom u_geom (
    .clk(clk), .rst(rst), .en(en), .v_in(in_valid && in_ready), .d_in(in_data),
    .ts(ts), .v_out(gv), .g(g)
  );

  cac_weight u_weight (
    .clk(clk), .rst(rst), .en(en), .v_in(gv), .g(g), .v_out(wv), .w(w)
  );

  cac_div_quot u_div_quot (
    .clk(clk), .en(en), .dividend(w.dividend), .divisor(w.divisor), .quot(quot)
  );

  cac_div_cent u_div_cent (
    .clk(clk), .en(en), .num_x(w.num_x), .num_y(w.num_y), .den(w.den),
    .qx(qx), .qy(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) vd[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vd[0] <= wv;
      for (int k = 1; k <= QB; k++) vd[k] <= vd[k-1];
      out_valid <= vd[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= w.side;
      for (int k = 1; k <= QB; k++) sd[k] <= sd[k-1];
      cx[0] <= qx;
      cy[0] <= qy;
      for (int k = 1; k < CENT_DLY; k++) begin
        cx[k] <= cx[k-1];
        cy[k] <= cy[k-1];
      end
      out_data.centroid_x <= sd[QB].zero ? '0 : clamp(fx);
      out_data.centroid_y <= sd[QB].zero ? '0 : clamp(fy);
      out_data.cell_area <= sd[QB].area;
      out_data.step_over_area <= quot;
      out_data.degenerate <= sd[QB].degen;
    end
  end

  always_comb begin
    fx = sd[QB].neg_x ? -SW'(cx[CENT_DLY-1]) : SW'(cx[CENT_DLY-1]);
    fy = sd[QB].neg_y ? -SW'(cy[CENT_DLY-1]) : SW'(cy[CENT_DLY-1]);
  end

  function automatic logic signed [CW-1:0] clamp(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SW'(8388607)) r = 24'sh7FFFFF;
    else if (v < -SW'(8388608)) r = 24'sh800000;
    else r = v[CW-1:0];
    return r;
  endfunction

  a_degen_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.step_over_area == '1)
    else $error("Degenerate cell without saturated quotient.");

  a_degen_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.cell_area == '0)
    else $error("Degenerate cell with nonzero area.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input blocked while the output register is empty.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vd[QB]) && $stable(sd[QB]))
    else $error("Pipeline moved during an output stall.");

endmodule

FILE: bench/cell_area_centroid_test.sv
`timescale 1ns / 1ps
// Self-checking bench for cell_area_centroid: a directed table of cells, then random cells
// under changing idle patterns and time steps, scored against a built-in predictor.
// Depends on cac_pkg and the cell_area_centroid RTL.
module cell_area_centroid_test;
  import cac_pkg::*;

  localparam int LATENCY = 47;
  localparam int WATCHDOG = 4000;
  localparam int RANDOM_CELLS = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  cell_area_centroid dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    in_t  stim;
    logic known;
    out_t result;
  } row_t;

  logic [31:0] step_reg = TS_RESET;
  out_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 1'b0;

  function automatic longint tri_area2(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
    longint cr;
    cr = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (cr < 0) cr = -cr;
    return cr >>> 17;
  endfunction

  function automatic out_t measure_cell(in_t c, logic [31:0] ts);
    out_t r;
    longint x0, y0, x1, y1, x2, y2, x3, y3, sxa, sya, sxb, syb;
    longint aa, ab, tot, area, cx, cy;
    logic [79:0] num;
    logic [79:0] q;
    x0 = c.node0_x; y0 = c.node0_y; x1 = c.node1_x; y1 = c.node1_y;
    x2 = c.node2_x; y2 = c.node2_y; x3 = c.node3_x; y3 = c.node3_y;
    sxa = x0 + x1 + x2; sya = y0 + y1 + y2;
    aa = tri_area2(x0, y0, x1, y1, x2, y2);
    if (c.cell_type == CELL_TRI) begin
      area = aa; cx = sxa / 3; cy = sya / 3;
    end else begin
      sxb = x0 + x3 + x2; syb = y0 + y3 + y2;
      ab = tri_area2(x0, y0, x3, y3, x2, y2);
      tot = aa + ab;
      area = (tot > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tot;
      if (tot == 0) begin
        cx = 0; cy = 0;
      end else begin
        cx = (aa * sxa + ab * sxb) / (3 * tot);
        cy = (aa * sya + ab * syb) / (3 * tot);
      end
    end
    if (cx > 8388607) cx = 8388607;
    if (cx < -8388608) cx = -8388608;
    if (cy > 8388607) cy = 8388607;
    if (cy < -8388608) cy = -8388608;
    r.centroid_x = cx[23:0];
    r.centroid_y = cy[23:0];
    r.cell_area = area[31:0];
    r.degenerate = (area == 0);
    if (area == 0) begin
      r.step_over_area = '1;
    end else begin
      num = {32'd0, ts, 16'd0};
      q = num / area;
      r.step_over_area = (q > 80'hFF_FFFF_FFFF) ? '1 : q[39:0];
    end
    return r;
  endfunction

  function automatic in_t cell_of(logic ct, int a0, int b0, int a1, int b1,
                                  int a2, int b2, int a3, int b3);
    in_t c;
    c.cell_type = ct;
    c.node0_x = 24'(a0); c.node0_y = 24'(b0); c.node1_x = 24'(a1); c.node1_y = 24'(b1);
    c.node2_x = 24'(a2); c.node2_y = 24'(b2); c.node3_x = 24'(a3); c.node3_y = 24'(b3);
    return c;
  endfunction

  function automatic logic [23:0] rand_coord(int span_bits);
    logic [23:0] v;
    if (span_bits >= 24) begin
      v = 24'($urandom);
    end else begin
      v = 24'($urandom_range((1 << span_bits) - 1, 0));
      if ($urandom_range(1, 0)) v = -v;
    end
    return v;
  endfunction

  function automatic in_t random_cell();
    in_t c;
    int span;
    int pick;
    pick = $urandom_range(9, 0);
    span = (pick < 6) ? $urandom_range(23, 14) : ((pick < 8) ? 24 : $urandom_range(8, 1));
    c.cell_type = 1'($urandom_range(1, 0));
    c.node0_x = rand_coord(span); c.node0_y = rand_coord(span);
    c.node1_x = rand_coord(span); c.node1_y = rand_coord(span);
    c.node2_x = rand_coord(span); c.node2_y = rand_coord(span);
    c.node3_x = rand_coord(span); c.node3_y = rand_coord(span);
    if ($urandom_range(19, 0) == 0) begin
      c.node1_x = c.node0_x; c.node1_y = c.node0_y;
      c.node3_x = c.node2_x; c.node3_y = c.node2_y;
    end
    return c;
  endfunction

  task automatic send_cell(in_t c);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    pending_results.push_back(measure_cell(c, step_reg));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_step(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    step_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer: %p", out_data);
      end else begin
        out_t want;
        want = pending_results.pop_front();
        if (out_data.centroid_x !== want.centroid_x ||
            out_data.centroid_y !== want.centroid_y ||
            out_data.cell_area !== want.cell_area ||
            out_data.step_over_area !== want.step_over_area ||
            out_data.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) timed_out = 1'b1;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    out_t typed;
    logic [31:0] steps[6];
    int phase;
    steps = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'h0100_0000, 32'h7FFF_0000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    typed = '{centroid_x: 24'd0, centroid_y: 24'd0, cell_area: 32'd0,
              step_over_area: '1, degenerate: 1'b1};
    rows.push_back('{cell_of(CELL_TRI, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, typed});
    typed = '{centroid_x: 24'd0, centroid_y: 24'd0, cell_area: 32'h0002_0000,
              step_over_area: 40'h00_0080_0000, degenerate: 1'b0};
    rows.push_back('{cell_of(CELL_TRI, -65536 * 2, 0, 65536 * 2, 0, 0, 0, 0, 0), 1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, 0, 0, 131072, 0, 0, 131072, 0, 0), 1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 65536, 0, 65536, 65536, 0, 65536), 1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 1, 0, 1, 1, 0, 1), 1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, -8388608, -8388608, 8388607, -8388608,
                             8388607, 8388607, 0, 0), 1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, -8388608, -8388608, 8388607, -8388608,
                             8388607, 8388607, -8388608, 8388607), 1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, -8388608, -8388608, -8388608, -8388608,
                             -8388608, -8388608, 0, 0), 1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, 8388607, 8388607, 8388607, 8388607,
                             8388607, 8388607, -1, -1), 1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 65536, 0, 0, 0, 65536, 0), 1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 65536, 65536, 131072, 0, 65536, -65536),
                    1'b0, typed});
    rows.push_back('{cell_of(CELL_QUAD, 0, 0, 65536, 65536, 131072, 0, 65536, 65536),
                    1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, -5, 7, 3, -2, 1, 9, 8388607, -8388608), 1'b0, typed});
    rows.push_back('{cell_of(CELL_TRI, 0, 0, 65536, 0, 0, 65536, 0, 0), 1'b0, typed});

    foreach (rows[i]) begin
      if (rows[i].known) begin
        out_t m;
        m = measure_cell(rows[i].stim, step_reg);
        if (m !== rows[i].result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Table row %0d disagrees with predictor: %p vs %p", i, rows[i].result, m);
        end
      end
      send_cell(rows[i].stim);
    end
    drain();

    for (phase = 0; phase < 8; phase++) begin
      write_step(steps[phase % 6] ^ ((phase >= 6) ? $urandom : 32'd0));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int k = 0; k < RANDOM_CELLS / 8; k++) begin
        if (k == 100) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_results.size() != 0);
        end
        send_cell(random_cell());
      end
      drain();
    end
    recv_stall_pct = 0;
    write_step(TS_RESET);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("Watchdog expired with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
